FILE: src/efpa_pkg.sv
`timescale 1ns / 1ps
package efpa_pkg;

  localparam int unsigned FRAME_W = 16;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned OFS_W   = 18;
  localparam int unsigned DEG_W   = 19;
  localparam int unsigned RAD_W   = 21;
  localparam int unsigned GOOD_W  = 32;
  localparam int unsigned ERR_W   = 16;

  // scaled = floor((pos*184320 + 16383) / 32766), reduced by 3:
  // floor((pos*61440 + 5461) / 10922), done as a round-up reciprocal multiply
  localparam int unsigned SCL_W     = 17;
  localparam int unsigned NUM_W     = 30;
  localparam int unsigned RECIP_W   = 31;
  localparam int unsigned RPROD_W   = NUM_W + RECIP_W;
  localparam int unsigned RECIP_SH  = 44;
  localparam logic [NUM_W-1:0]   DEG_NUM  = NUM_W'(61440);
  localparam logic [NUM_W-1:0]   DEG_BIAS = NUM_W'(5461);
  localparam logic [RECIP_W-1:0] DEG_RECIP = RECIP_W'(1610711047);

  // wide signed working width for offset correction
  localparam int unsigned DIFF_W = 20;
  localparam logic signed [DIFF_W-1:0] DEG_MAX = 20'sd184320;
  localparam logic signed [DIFF_W-1:0] DEG_MIN = -20'sd184320;
  localparam int unsigned MAG_W = 18;

  // rad = round(mag * 4685083 / 2^20), halves away from zero
  localparam int unsigned RMUL_W  = 23;
  localparam int unsigned RSH     = 20;
  localparam int unsigned RADP_W  = MAG_W + RMUL_W;
  localparam logic [RMUL_W-1:0] RAD_MUL  = RMUL_W'(4685083);
  localparam logic [RADP_W-1:0] RAD_HALF = RADP_W'(1) << (RSH - 1);

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIRECTION = 1'b1;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ld_t;

  typedef struct packed {
    logic                    ok;
    logic [POS_W-1:0]        pos;
    logic signed [DEG_W-1:0] deg;
    logic signed [RAD_W-1:0] rad;
  } conv_res_t;

endpackage

FILE: src/efpa_datapath.sv
`timescale 1ns / 1ps
module efpa_datapath
  import efpa_pkg::*;
(
  input  logic                    clk_i,
  input  pipe_ld_t                ld_i,
  input  logic [FRAME_W-1:0]      raw_frame_i,
  input  logic signed [OFS_W-1:0] offset_i,
  input  logic                    reverse_i,
  output conv_res_t               res_o
);

  // stage 1: frame register
  logic [FRAME_W-1:0] frame_q;

  // stage 2: parity and scaled angle
  logic             s2_ok_q;
  logic [POS_W-1:0] s2_pos_q;
  logic [SCL_W-1:0] s2_scl_q;

  // stage 3: corrected angle, sign and magnitude
  logic                    s3_ok_q;
  logic [POS_W-1:0]        s3_pos_q;
  logic signed [DEG_W-1:0] s3_deg_q;
  logic [MAG_W-1:0]        s3_mag_q;
  logic                    s3_neg_q;

  logic                      par_ok;
  logic [NUM_W-1:0]          num;
  logic [RPROD_W-1:0]        rprod;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  dir;
  logic signed [DIFF_W-1:0]  clamped;
  logic signed [DIFF_W-1:0]  absval;
  logic [RADP_W-1:0]         radp;
  logic [RAD_W-1:0]          rmag;

  // odd parity: bit 14 over even bits, bit 15 over odd bits
  assign par_ok = (^(frame_q & 16'h5555)) & (^(frame_q & 16'hAAAA));
  assign num    = NUM_W'(frame_q[POS_W-1:0]) * DEG_NUM + DEG_BIAS;
  assign rprod  = RPROD_W'(num) * RPROD_W'(DEG_RECIP);

  always_comb begin
    diff = $signed({{(DIFF_W-SCL_W){1'b0}}, s2_scl_q}) - DIFF_W'(offset_i);
    dir  = reverse_i ? -diff : diff;
    if (dir > DEG_MAX) begin
      clamped = DEG_MAX;
    end else if (dir < DEG_MIN) begin
      clamped = DEG_MIN;
    end else begin
      clamped = dir;
    end
    absval = clamped[DIFF_W-1] ? -clamped : clamped;
  end

  assign radp = RADP_W'(s3_mag_q) * RADP_W'(RAD_MUL) + RAD_HALF;
  assign rmag = RAD_W'(radp[RADP_W-1:RSH]);

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      frame_q <= raw_frame_i;
    end
    if (ld_i.ld2) begin
      s2_ok_q  <= par_ok;
      s2_pos_q <= frame_q[POS_W-1:0];
      s2_scl_q <= rprod[RECIP_SH+SCL_W-1:RECIP_SH];
    end
    if (ld_i.ld3) begin
      s3_ok_q  <= s2_ok_q;
      s3_pos_q <= s2_pos_q;
      s3_deg_q <= clamped[DEG_W-1:0];
      s3_mag_q <= absval[MAG_W-1:0];
      s3_neg_q <= clamped[DIFF_W-1];
    end
  end

  always_comb begin
    res_o.ok  = s3_ok_q;
    res_o.pos = s3_pos_q;
    res_o.deg = s3_deg_q;
    res_o.rad = s3_neg_q ? -$signed(rmag) : $signed(rmag);
  end

endmodule

FILE: src/encoder_frame_parity_angle_core.sv
`timescale 1ns / 1ps
// A result passes through the frame register, the scaling multiply, the
// offset/clamp and the radian multiply into the result register. Throughput:
// one item per cycle while out_stall_i is low, set by the 4-stage pipeline.
// Reset (async, active low): config to zero, held angles, position and both
// counters to zero, pipeline empty.
module encoder_frame_parity_angle_core
  import efpa_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [FRAME_W-1:0]          raw_frame_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        parity_ok_o,
  output logic [POS_W-1:0]            position_o,
  output logic signed [DEG_W-1:0]     angle_degrees_o,
  output logic signed [RAD_W-1:0]     angle_radians_o,
  output logic [GOOD_W-1:0]           good_reads_o,
  output logic [ERR_W-1:0]            parity_errors_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [OFS_W-1:0]            cfg_data_i
);

  logic                    s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic                    s1_free, s2_free, s3_free, out_free;
  pipe_ld_t                ld;
  conv_res_t               res;

  logic signed [OFS_W-1:0] offset_q;
  logic                    reverse_q;

  logic                    ok_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [DEG_W-1:0] deg_q;
  logic signed [RAD_W-1:0] rad_q;
  logic [GOOD_W-1:0]       good_q;
  logic [ERR_W-1:0]        err_q;

  // a stage takes new data when it is empty or its item moves on
  assign out_free = !out_vld_q || !out_stall_i;
  assign s3_free  = !s3_vld_q || out_free;
  assign s2_free  = !s2_vld_q || s3_free;
  assign s1_free  = !s1_vld_q || s2_free;

  assign in_stall_o = !s1_free;
  assign ld.ld1     = s1_free && in_valid_i;
  assign ld.ld2     = s2_free && s1_vld_q;
  assign ld.ld3     = s3_free && s2_vld_q;

  assign cfg_ready_o = 1'b1;

  efpa_datapath u_datapath (
    .clk_i       (clk_i),
    .ld_i        (ld),
    .raw_frame_i (raw_frame_i),
    .offset_i    (offset_q),
    .reverse_i   (reverse_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      reverse_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ANGLE_OFFSET:      offset_q  <= $signed(cfg_data_i);
        CFG_REVERSE_DIRECTION: reverse_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free)  s1_vld_q  <= in_valid_i;
      if (s2_free)  s2_vld_q  <= s1_vld_q;
      if (s3_free)  s3_vld_q  <= s2_vld_q;
      if (out_free) out_vld_q <= s3_vld_q;
    end
  end

  // result register doubles as the held state and the counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q   <= 1'b0;
      pos_q  <= '0;
      deg_q  <= '0;
      rad_q  <= '0;
      good_q <= '0;
      err_q  <= '0;
    end else if (out_free && s3_vld_q) begin
      ok_q <= res.ok;
      if (res.ok) begin
        pos_q <= res.pos;
        deg_q <= res.deg;
        rad_q <= res.rad;
        if (good_q != '1) good_q <= good_q + GOOD_W'(1);
        if (err_q != '0)  err_q  <= err_q - ERR_W'(1);
      end else begin
        if (err_q != '1)  err_q  <= err_q + ERR_W'(1);
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign parity_ok_o     = ok_q;
  assign position_o      = pos_q;
  assign angle_degrees_o = deg_q;
  assign angle_radians_o = rad_q;
  assign good_reads_o    = good_q;
  assign parity_errors_o = err_q;

endmodule

FILE: sim/tb_encoder_frame_parity_angle_core.sv
`timescale 1ns / 1ps
module tb_encoder_frame_parity_angle_core
  import efpa_pkg::*;
;

  localparam longint DEG_FULL   = 184320;  // clamp limit, 720 deg in 1/256 deg
  localparam longint SCALE_MUL  = 184320;  // 2 * 92160
  localparam longint SCALE_DIV  = 32766;   // 2 * 16383
  localparam longint SCALE_RND  = 16383;
  localparam longint RAD_K      = 4685083; // 2^20 * 256 * pi / 180
  localparam longint RAD_RND    = 524288;
  localparam int     SETTLE     = 8;
  localparam int     SEG_ITEMS  = 200;
  localparam int     BURST_ITEMS = 60;
  localparam int     MAX_REPORT = 10;

  typedef struct {
    logic                    ok;
    logic [POS_W-1:0]        pos;
    logic signed [DEG_W-1:0] deg;
    logic signed [RAD_W-1:0] rad;
    logic [GOOD_W-1:0]       good;
    logic [ERR_W-1:0]        errs;
  } reading_t;

  typedef struct {
    logic     given;
    reading_t r;
  } pinned_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [FRAME_W-1:0]  frame;
    logic                given;
    reading_t            r;
    logic [CFG_IDX_W-1:0] idx;
    logic [OFS_W-1:0]    data;
  } row_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [FRAME_W-1:0]      raw_frame_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    parity_ok_o;
  logic [POS_W-1:0]        position_o;
  logic signed [DEG_W-1:0] angle_degrees_o;
  logic signed [RAD_W-1:0] angle_radians_o;
  logic [GOOD_W-1:0]       good_reads_o;
  logic [ERR_W-1:0]        parity_errors_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [OFS_W-1:0]        cfg_data_i  = '0;

  // predictor state
  logic signed [OFS_W-1:0] zero_offset;
  logic                    reversed;
  logic [POS_W-1:0]        last_pos;
  logic signed [DEG_W-1:0] last_deg;
  logic signed [RAD_W-1:0] last_rad;
  logic [GOOD_W-1:0]       good_count;
  logic [ERR_W-1:0]        err_count;

  reading_t angle_q[$];
  pinned_t  pinned_q[$];
  row_t     plan[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int frames_seen   = 0;
  int frames_bad    = 0;
  int reg_writes    = 0;
  int err_peak      = 0;
  bit failed        = 1'b0;

  encoder_frame_parity_angle_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_frame_i     (raw_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .parity_ok_o     (parity_ok_o),
    .position_o      (position_o),
    .angle_degrees_o (angle_degrees_o),
    .angle_radians_o (angle_radians_o),
    .good_reads_o    (good_reads_o),
    .parity_errors_o (parity_errors_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // frame with both check bits set for odd parity
  function automatic logic [FRAME_W-1:0] seal(input logic [POS_W-1:0] p);
    return {~^(p & 14'h2AAA), ~^(p & 14'h1555), p};
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return POS_W'($urandom_range(16383));
  endfunction

  // mostly clean frames, the rest corrupted or pure noise
  function automatic logic [FRAME_W-1:0] pick_frame();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return seal(pick_pos());
    if (sel < 85) return seal(pick_pos()) ^ (16'h0001 << $urandom_range(15));
    if (sel < 95) return seal(pick_pos()) ^ FRAME_W'($urandom);
    return FRAME_W'($urandom);
  endfunction

  function automatic reading_t decode_frame(input logic [FRAME_W-1:0] f);
    reading_t r;
    logic [POS_W-1:0] p;
    longint s, d, mag, q;
    r.ok = (^(f & 16'h5555)) && (^(f & 16'hAAAA));
    if (r.ok) begin
      p = f[POS_W-1:0];
      s = (longint'(p) * SCALE_MUL + SCALE_RND) / SCALE_DIV;
      d = s - longint'(zero_offset);
      if (reversed) d = -d;
      if (d > DEG_FULL) d = DEG_FULL;
      else if (d < -DEG_FULL) d = -DEG_FULL;
      mag = (d < 0) ? -d : d;
      q = (mag * RAD_K + RAD_RND) >>> 20;
      last_pos = p;
      last_deg = DEG_W'(d);
      last_rad = RAD_W'((d < 0) ? -q : q);
      if (good_count != '1) good_count++;
      if (err_count != '0) err_count--;
    end else if (err_count != '1) begin
      err_count++;
    end
    r.pos  = last_pos;
    r.deg  = last_deg;
    r.rad  = last_rad;
    r.good = good_count;
    r.errs = err_count;
    return r;
  endfunction

  // everything is sampled at the falling edge; the next rising edge moves it
  always @(negedge clk_i) begin
    reading_t want, got, calc;
    pinned_t  pin;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{parity_ok_o, position_o, angle_degrees_o, angle_radians_o,
                good_reads_o, parity_errors_o};
        if (angle_q.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("%t: unexpected result, nothing pending", $realtime);
        end else begin
          want = angle_q.pop_front();
          if (got.ok !== want.ok || got.pos !== want.pos || got.deg !== want.deg ||
              got.rad !== want.rad || got.good !== want.good ||
              got.errs !== want.errs) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= MAX_REPORT) begin
              $display("%t: mismatch exp ok=%0d pos=%0d deg=%0d rad=%0d good=%0d err=%0d",
                       $realtime, want.ok, want.pos, want.deg, want.rad, want.good,
                       want.errs);
              $display("%t:          got ok=%0d pos=%0d deg=%0d rad=%0d good=%0d err=%0d",
                       $realtime, got.ok, got.pos, got.deg, got.rad, got.good,
                       got.errs);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pin  = pinned_q.pop_front();
        calc = decode_frame(raw_frame_i);
        frames_seen++;
        if (!calc.ok) frames_bad++;
        if (int'(err_count) > err_peak) err_peak = err_count;
        angle_q.push_back(pin.given ? pin.r : calc);
      end
    end
  end

  task automatic push_frame(input logic [FRAME_W-1:0] f, input logic given,
                            input reading_t r);
    logic taken;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pinned_q.push_back('{given, r});
    in_valid_i  <= 1'b1;
    raw_frame_i <= f;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [OFS_W-1:0] val);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    if (idx == CFG_ANGLE_OFFSET) zero_offset = val;
    else reversed = val[0];
    reg_writes++;
  endtask

  task automatic drain();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic row_t frame_row(input logic [FRAME_W-1:0] f);
    row_t w;
    w = '{ROW_FRAME, f, 1'b0, '{1'b0, '0, '0, '0, '0, '0}, '0, '0};
    return w;
  endfunction

  function automatic row_t typed_row(input logic [FRAME_W-1:0] f, input reading_t r);
    row_t w;
    w = frame_row(f);
    w.given = 1'b1;
    w.r = r;
    return w;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [OFS_W-1:0] val);
    row_t w;
    w = frame_row('0);
    w.kind = ROW_CFG;
    w.idx  = idx;
    w.data = val;
    return w;
  endfunction

  initial begin
    #(10_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    reading_t none;
    logic signed [OFS_W-1:0] ofs_set[9];
    zero_offset = '0;
    reversed    = 1'b0;
    last_pos    = '0;
    last_deg    = '0;
    last_rad    = '0;
    good_count  = '0;
    err_count   = '0;
    none = '{1'b0, '0, '0, '0, '0, '0};
    ofs_set = '{18'sd0, 18'sd92160, -18'sd92160, 18'sd131071, -18'sd131072,
                18'sd5000, '0, '0, '0};

    // directed: reset state, counter floor, bad check bits, clamp both ways
    plan.push_back(typed_row(16'h0000, '{1'b0, 14'd0, 19'sd0, 21'sd0, 32'd0, 16'd1}));
    plan.push_back(typed_row(16'hC000, '{1'b1, 14'd0, 19'sd0, 21'sd0, 32'd1, 16'd0}));
    plan.push_back(typed_row(16'hC000, '{1'b1, 14'd0, 19'sd0, 21'sd0, 32'd2, 16'd0}));
    plan.push_back(typed_row(16'h3FFF, '{1'b1, 14'h3FFF, 19'sd92160, 21'sd411775,
                                         32'd3, 16'd0}));
    plan.push_back(typed_row(16'h7FFF, '{1'b0, 14'h3FFF, 19'sd92160, 21'sd411775,
                                         32'd3, 16'd1}));
    plan.push_back(typed_row(16'hBFFF, '{1'b0, 14'h3FFF, 19'sd92160, 21'sd411775,
                                         32'd3, 16'd2}));
    plan.push_back(typed_row(16'hFFFF, '{1'b0, 14'h3FFF, 19'sd92160, 21'sd411775,
                                         32'd3, 16'd3}));
    plan.push_back(typed_row(16'h0001, '{1'b0, 14'h3FFF, 19'sd92160, 21'sd411775,
                                         32'd3, 16'd4}));
    plan.push_back(cfg_row(CFG_ANGLE_OFFSET, 18'h20000));
    plan.push_back(typed_row(16'h3FFF, '{1'b1, 14'h3FFF, 19'sd184320, 21'sd823550,
                                         32'd4, 16'd3}));
    plan.push_back(cfg_row(CFG_REVERSE_DIRECTION, 18'd1));
    plan.push_back(typed_row(16'h3FFF, '{1'b1, 14'h3FFF, -19'sd184320, -21'sd823550,
                                         32'd5, 16'd2}));
    plan.push_back(cfg_row(CFG_ANGLE_OFFSET, 18'h1FFFF));
    plan.push_back(frame_row(16'hC000));
    plan.push_back(frame_row(seal(14'h1555)));
    plan.push_back(frame_row(seal(14'h2AAA)));
    plan.push_back(frame_row(seal(14'h2000)));
    plan.push_back(cfg_row(CFG_ANGLE_OFFSET, 18'd0));
    plan.push_back(cfg_row(CFG_REVERSE_DIRECTION, 18'd0));
    plan.push_back(frame_row(seal(14'h1FFF)));
    plan.push_back(frame_row(seal(14'h0001)));
    plan.push_back(frame_row(seal(14'h0001) ^ 16'h0002));
    plan.push_back(frame_row(seal(14'h3FFE) ^ 16'h2000));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 11;
    recv_idle_pct = 83;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_frame(plan[i].frame, plan[i].given, plan[i].r);
      end
    end

    // random segments; each starts idle with a new setting, which also
    // stops the sender until every pending result is back
    for (int seg = 0; seg < 9; seg++) begin
      send_idle_pct = (seg < 3) ? 11 : (seg < 6) ? 83 : 0;
      recv_idle_pct = (seg < 3) ? 83 : (seg < 6) ? 11 : 0;
      drain();
      write_reg(CFG_ANGLE_OFFSET,
                (seg >= 6) ? OFS_W'($urandom) : OFS_W'(ofs_set[seg]));
      write_reg(CFG_REVERSE_DIRECTION, OFS_W'(seg % 2));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        push_frame(pick_frame(), 1'b0, none);
      end
    end

    // a burst of failing frames drives the error count up, then it backs off
    for (int n = 0; n < BURST_ITEMS; n++) begin
      push_frame(seal(pick_pos()) ^ 16'h4000, 1'b0, none);
    end
    for (int n = 0; n < 40; n++) begin
      push_frame(($urandom_range(3) == 0) ? pick_frame() : seal(pick_pos()), 1'b0, none);
    end

    drain();
    $display("Covered %0d frames, %0d failing the check bits, %0d register writes;",
             frames_seen, frames_bad, reg_writes);
    $display("error count peaked at %0d, %0d mismatches seen.", err_peak, mismatches);
    if (!failed) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: encoder_frame_parity_angle_core.f
src/efpa_pkg.sv
src/efpa_datapath.sv
src/encoder_frame_parity_angle_core.sv
sim/tb_encoder_frame_parity_angle_core.sv
